// ----- rtl/core/pei_pkg.sv -----
// ----------------------------------------------------------------------------
// pei_pkg
// Shared types, codes, constants and table builders for the damped Euler
// particle integrator.
// ----------------------------------------------------------------------------
package pei_pkg;

    // fixed point format and field widths
    localparam int FRAC_BITS           = 16;
    localparam int ONE_Q               = 1 << FRAC_BITS;
    localparam int Q_W                 = 32;
    localparam int DAMP_W              = 17;
    localparam int MASS_W              = 32;
    localparam int DT_W                = 16;
    localparam int REQ_W               = 3;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 32;
    localparam int POW_ENTRIES_DEFAULT = 256;

    // precision used while building the log2 and exp2 tables
    localparam int HP_BITS = 30;

    typedef logic [2:0][Q_W-1:0] vec_t;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_FORCE = 3'd0,
        REQ_CLEAR     = 3'd1,
        REQ_INTEGRATE = 3'd2,
        REQ_LOAD_POS  = 3'd3,
        REQ_LOAD_VEL  = 3'd4
    } req_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DAMPING  = 3'd0,
        CFG_INV_MASS = 3'd1,
        CFG_ACCEL_X  = 3'd2,
        CFG_ACCEL_Y  = 3'd3,
        CFG_ACCEL_Z  = 3'd4
    } cfg_idx_t;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_SIMPLE,
        OP_SKIP,
        OP_DAMP_INIT,
        OP_IDX,
        OP_TAB_LO,
        OP_TAB_HI,
        OP_MUL_INT,
        OP_LOG_DONE,
        OP_MUL_E,
        OP_EXP_PREP,
        OP_EXP_DONE,
        OP_MUL_PV,
        OP_POS_FM,
        OP_ACC,
        OP_MUL_AD,
        OP_VSUM,
        OP_MUL_VF,
        OP_VEL
    } op_t;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_L_IDX,
        ST_L_LO,
        ST_L_HI,
        ST_L_MUL,
        ST_L_DONE,
        ST_E_MUL,
        ST_E_PREP,
        ST_X_IDX,
        ST_X_LO,
        ST_X_HI,
        ST_X_MUL,
        ST_X_DONE,
        ST_A0,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_A4,
        ST_A5,
        ST_A6,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       take;
        logic       load_out;
        op_t        op;
        logic [1:0] ax;
    } dp_cmd_t;

    typedef struct packed {
        logic req_integrate;
        logic inv_mass_zero;
        logic damp_trivial;
    } dp_status_t;

    // integer square root, bit by bit
    function automatic logic [63:0] pei_isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] rem;
        logic        started;
        r       = '0;
        rem     = v;
        started = 1'b0;
        for (int k = 0; k < 32; k++) begin
            b = 64'd1 << (62 - 2 * k);
            if (started || (b <= rem)) begin
                started = 1'b1;
                if (rem >= r + b) begin
                    rem = rem - (r + b);
                    r   = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
            end
        end
        return r;
    endfunction

    // log2 of a value in [1,2) held with HP_BITS fraction bits
    function automatic logic [63:0] pei_log2_hp(input logic [63:0] u_in);
        logic [63:0] u;
        logic [63:0] res;
        u   = u_in;
        res = '0;
        for (int k = 0; k < HP_BITS; k++) begin
            u   = (u * u) >> HP_BITS;
            res = res << 1;
            if (u >= (64'd1 << (HP_BITS + 1))) begin
                u   = u >> 1;
                res = res | 64'd1;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] pei_round_hp(input logic [63:0] x);
        return (x + (64'd1 << (HP_BITS - FRAC_BITS - 1))) >> (HP_BITS - FRAC_BITS);
    endfunction

    // log2(1 + f) rounded to the working fraction
    function automatic logic [63:0] pei_log_entry(input logic [63:0] f);
        return pei_round_hp(pei_log2_hp((64'd1 << HP_BITS) + f));
    endfunction

    // 2^f from a product of repeated square roots of two
    function automatic logic [63:0] pei_exp_entry(input logic [63:0] f);
        logic [63:0] rt;
        logic [63:0] r;
        rt = 64'd2 << HP_BITS;
        r  = 64'd1 << HP_BITS;
        for (int k = 1; k <= HP_BITS; k++) begin
            rt = pei_isqrt(rt << HP_BITS);
            if (f[HP_BITS-k]) begin
                r = (r * rt) >> HP_BITS;
            end
        end
        return pei_round_hp(r);
    endfunction

endpackage

// ----- rtl/core/pei_ctrl.sv -----
// ----------------------------------------------------------------------------
// pei_ctrl
// Sequencer for the integrator: accepts items, steps the datapath through
// the damping power and the per-axis update, and holds the result valid.
// ----------------------------------------------------------------------------
module pei_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  pei_pkg::dp_status_t  status,
    output pei_pkg::dp_cmd_t     cmd
);
    import pei_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] ax_reg, ax_next;
    logic       out_vld_reg, out_vld_next;

    // state, axis counter and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ax_reg      <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ax_reg      <= ax_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        ax_next      = ax_reg;
        out_vld_next = out_vld_reg && !m_ready;
        cmd.take     = 1'b0;
        cmd.load_out = 1'b0;
        cmd.op       = OP_NONE;
        cmd.ax       = ax_reg;
        s_ready      = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                ax_next = '0;
                if (!status.req_integrate) begin
                    cmd.op     = OP_SIMPLE;
                    state_next = ST_FINISH;
                end else if (status.inv_mass_zero) begin
                    cmd.op     = OP_SKIP;
                    state_next = ST_FINISH;
                end else begin
                    cmd.op     = OP_DAMP_INIT;
                    state_next = status.damp_trivial ? ST_A0 : ST_L_IDX;
                end
            end
            // log2 of the damping mantissa
            ST_L_IDX: begin
                cmd.op     = OP_IDX;
                state_next = ST_L_LO;
            end
            ST_L_LO: begin
                cmd.op     = OP_TAB_LO;
                state_next = ST_L_HI;
            end
            ST_L_HI: begin
                cmd.op     = OP_TAB_HI;
                state_next = ST_L_MUL;
            end
            ST_L_MUL: begin
                cmd.op     = OP_MUL_INT;
                state_next = ST_L_DONE;
            end
            ST_L_DONE: begin
                cmd.op     = OP_LOG_DONE;
                state_next = ST_E_MUL;
            end
            // scale by dt and split the exponent
            ST_E_MUL: begin
                cmd.op     = OP_MUL_E;
                state_next = ST_E_PREP;
            end
            ST_E_PREP: begin
                cmd.op     = OP_EXP_PREP;
                state_next = ST_X_IDX;
            end
            // exp2 of the fractional part
            ST_X_IDX: begin
                cmd.op     = OP_IDX;
                state_next = ST_X_LO;
            end
            ST_X_LO: begin
                cmd.op     = OP_TAB_LO;
                state_next = ST_X_HI;
            end
            ST_X_HI: begin
                cmd.op     = OP_TAB_HI;
                state_next = ST_X_MUL;
            end
            ST_X_MUL: begin
                cmd.op     = OP_MUL_INT;
                state_next = ST_X_DONE;
            end
            ST_X_DONE: begin
                cmd.op     = OP_EXP_DONE;
                state_next = ST_A0;
            end
            // per-axis update
            ST_A0: begin
                cmd.op     = OP_MUL_PV;
                state_next = ST_A1;
            end
            ST_A1: begin
                cmd.op     = OP_POS_FM;
                state_next = ST_A2;
            end
            ST_A2: begin
                cmd.op     = OP_ACC;
                state_next = ST_A3;
            end
            ST_A3: begin
                cmd.op     = OP_MUL_AD;
                state_next = ST_A4;
            end
            ST_A4: begin
                cmd.op     = OP_VSUM;
                state_next = ST_A5;
            end
            ST_A5: begin
                cmd.op     = OP_MUL_VF;
                state_next = ST_A6;
            end
            ST_A6: begin
                cmd.op = OP_VEL;
                if (ax_reg == 2'd2) begin
                    state_next = ST_FINISH;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_A0;
                end
            end
            // wait for the output register to free up
            ST_FINISH: begin
                if (!out_vld_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_vld_reg;

endmodule

// ----- rtl/core/pei_datapath.sv -----
// ----------------------------------------------------------------------------
// pei_datapath
// Particle state, shared multiplier, log2/exp2 tables and the saturating
// adders; one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module pei_datapath #(
    parameter int POW_TABLE_ENTRIES = pei_pkg::POW_ENTRIES_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pei_pkg::dp_cmd_t             cmd,
    output pei_pkg::dp_status_t          status,
    input  logic [pei_pkg::REQ_W-1:0]    in_req,
    input  logic [pei_pkg::Q_W-1:0]      in_vec_x,
    input  logic [pei_pkg::Q_W-1:0]      in_vec_y,
    input  logic [pei_pkg::Q_W-1:0]      in_vec_z,
    input  logic [pei_pkg::DT_W-1:0]     in_dt,
    input  logic [pei_pkg::DAMP_W-1:0]   damping,
    input  logic [pei_pkg::MASS_W-1:0]   inv_mass,
    input  pei_pkg::vec_t                accel,
    output pei_pkg::vec_t                out_pos,
    output pei_pkg::vec_t                out_vel,
    output logic                         out_skipped,
    output logic                         out_saturated
);
    import pei_pkg::*;

    localparam int TW    = FRAC_BITS + 2;
    localparam int IW    = $clog2(POW_TABLE_ENTRIES + 1);
    localparam int TT    = FRAC_BITS + IW;
    localparam int NW    = FRAC_BITS + 5;
    localparam int NN    = NW - FRAC_BITS;
    localparam int PW    = $clog2(FRAC_BITS);
    localparam int FW    = FRAC_BITS + 1;
    localparam int MUL_W = Q_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W = PROD_W + 1;

    localparam logic [DAMP_W-1:0]      ONE_D   = DAMP_W'(ONE_Q);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

    // saturate to 32 bits, flag in the top bit
    function automatic logic [Q_W:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SAT_MAX) begin
            return {1'b1, 32'h7fff_ffff};
        end else if (v < SAT_MIN) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[Q_W-1:0]};
    endfunction

    // constant log2 and exp2 tables
    logic [TW-1:0] log_rom [POW_TABLE_ENTRIES+1];
    logic [TW-1:0] exp_rom [POW_TABLE_ENTRIES+1];

    for (genvar gi = 0; gi <= POW_TABLE_ENTRIES; gi++) begin : g_rom
        localparam logic [63:0] FPOS = (64'(gi) << HP_BITS) / POW_TABLE_ENTRIES;
        if (gi == POW_TABLE_ENTRIES) begin : g_end
            assign log_rom[gi] = TW'(ONE_Q);
            assign exp_rom[gi] = TW'(2 * ONE_Q);
        end else begin : g_mid
            assign log_rom[gi] = TW'(pei_log_entry(FPOS));
            assign exp_rom[gi] = TW'(pei_exp_entry(FPOS));
        end
    end

    // architectural state and latched item
    vec_t                pos_reg, pos_next;
    vec_t                vel_reg, vel_next;
    vec_t                frc_reg, frc_next;
    vec_t                vin_reg, vin_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [DT_W-1:0]     dt_reg, dt_next;
    logic                sat_reg, sat_next;
    logic                skip_reg, skip_next;

    // damping power scratch
    logic [FRAC_BITS-1:0] ifrac_reg, ifrac_next;
    logic                 tsel_reg, tsel_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [FRAC_BITS-1:0] rem_reg, rem_next;
    logic [TW-1:0]        lo_reg, lo_next;
    logic [TW-1:0]        hi_reg, hi_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [NW-1:0]        neg_reg, neg_next;
    logic [NN-1:0]        n_reg, n_next;
    logic                 gz_reg, gz_next;
    logic [FW-1:0]        factor_reg, factor_next;

    // axis scratch and multiplier output
    logic [Q_W-1:0]            a_reg, a_next;
    logic [Q_W-1:0]            v_reg, v_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;

    // result register
    vec_t out_pos_reg, out_vel_reg;
    logic out_skip_reg, out_sat_reg;

    // combinational helpers
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [TW:0]       diff_tab;
    logic [IW-1:0]            tab_addr;
    logic [TW-1:0]            tab_q;
    logic [TT-1:0]            t_scaled;
    logic [DAMP_W-1:0]        d_clamp;
    logic [PW-1:0]            p_c;
    logic [2*FRAC_BITS:0]     d_shift;
    logic signed [TW+1:0]     interp_res;
    logic [TW:0]              eh_pos;
    logic [NW-1:0]            neg_base;
    logic signed [NW:0]       neg_full;
    logic [NW-1:0]            e_val;
    logic [FRAC_BITS-1:0]     g_val;
    logic [FRAC_BITS:0]       one_minus_g;
    logic [Q_W:0]             s_tmp;

    // table read port
    assign tab_addr = (cmd.op == OP_TAB_HI) ? idx_reg + IW'(1) : idx_reg;
    assign tab_q    = tsel_reg ? exp_rom[tab_addr] : log_rom[tab_addr];
    assign diff_tab = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
    assign t_scaled = TT'(ifrac_reg) * TT'(POW_TABLE_ENTRIES);

    // interpolation result and shifted product
    assign prod_sh    = prod_reg >>> FRAC_BITS;
    assign interp_res = $signed({2'b00, lo_reg}) + $signed(prod_sh[TW+1:0]);
    assign eh_pos     = interp_res[TW+1] ? '0 : interp_res[TW:0];

    // clamped damping, leading one and mantissa fraction
    assign d_clamp = (damping > ONE_D) ? ONE_D : damping;
    always_comb begin
        p_c = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (d_clamp[i]) begin
                p_c = PW'(i);
            end
        end
    end
    assign d_shift = (2 * FRAC_BITS + 1)'(d_clamp[FRAC_BITS-1:0]) << (FRAC_BITS - int'(p_c));

    // exponent pieces
    assign neg_base    = NW'((FRAC_BITS - int'(p_reg)) * ONE_Q);
    assign neg_full    = $signed({1'b0, neg_base}) - (NW + 1)'(interp_res);
    assign e_val       = prod_reg[FRAC_BITS +: NW];
    assign g_val       = e_val[FRAC_BITS-1:0];
    assign one_minus_g = (FRAC_BITS + 1)'(ONE_Q) - {1'b0, g_val};

    // status to the controller
    assign status.req_integrate = (req_reg == REQ_INTEGRATE);
    assign status.inv_mass_zero = (inv_mass == '0);
    assign status.damp_trivial  = (dt_reg == '0) || (d_clamp == ONE_D) || (d_clamp == '0);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_INT: begin
                mul_a = MUL_W'(diff_tab);
                mul_b = MUL_W'(rem_reg);
            end
            OP_MUL_E: begin
                mul_a = MUL_W'(neg_reg);
                mul_b = MUL_W'(dt_reg);
            end
            OP_MUL_PV: begin
                mul_a = MUL_W'($signed(vel_reg[cmd.ax]));
                mul_b = MUL_W'(dt_reg);
            end
            OP_POS_FM: begin
                mul_a = MUL_W'($signed(frc_reg[cmd.ax]));
                mul_b = MUL_W'(inv_mass);
            end
            OP_MUL_AD: begin
                mul_a = MUL_W'($signed(a_reg));
                mul_b = MUL_W'(dt_reg);
            end
            OP_MUL_VF: begin
                mul_a = MUL_W'($signed(v_reg));
                mul_b = MUL_W'(factor_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign product = mul_a * mul_b;

    // next-state logic for all operations
    always_comb begin
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        frc_next    = frc_reg;
        vin_next    = vin_reg;
        req_next    = req_reg;
        dt_next     = dt_reg;
        sat_next    = sat_reg;
        skip_next   = skip_reg;
        ifrac_next  = ifrac_reg;
        tsel_next   = tsel_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        p_next      = p_reg;
        neg_next    = neg_reg;
        n_next      = n_reg;
        gz_next     = gz_reg;
        factor_next = factor_reg;
        a_next      = a_reg;
        v_next      = v_reg;
        prod_next   = prod_reg;
        s_tmp       = '0;

        // latch a new item
        if (cmd.take) begin
            req_next    = in_req;
            vin_next[0] = in_vec_x;
            vin_next[1] = in_vec_y;
            vin_next[2] = in_vec_z;
            dt_next     = in_dt;
            sat_next    = 1'b0;
            skip_next   = 1'b0;
        end

        unique case (cmd.op)
            OP_SIMPLE: begin
                unique case (req_reg)
                    REQ_ADD_FORCE: begin
                        for (int i = 0; i < 3; i++) begin
                            s_tmp = sat32(SUM_W'($signed(frc_reg[i]))
                                          + SUM_W'($signed(vin_reg[i])));
                            frc_next[i] = s_tmp[Q_W-1:0];
                            if (s_tmp[Q_W]) begin
                                sat_next = 1'b1;
                            end
                        end
                    end
                    REQ_CLEAR: begin
                        frc_next = '0;
                    end
                    REQ_LOAD_POS: begin
                        pos_next = vin_reg;
                    end
                    REQ_LOAD_VEL: begin
                        vel_next = vin_reg;
                    end
                    default: begin
                        frc_next = frc_reg;
                    end
                endcase
            end
            OP_SKIP: begin
                skip_next = 1'b1;
            end
            OP_DAMP_INIT: begin
                // trivial cases leave the factor here; others overwrite it
                factor_next = ((dt_reg == '0) || (d_clamp == ONE_D)) ? FW'(ONE_Q) : '0;
                p_next      = p_c;
                ifrac_next  = d_shift[FRAC_BITS-1:0];
                tsel_next   = 1'b0;
            end
            OP_IDX: begin
                idx_next = t_scaled[TT-1:FRAC_BITS];
                rem_next = t_scaled[FRAC_BITS-1:0];
            end
            OP_TAB_LO: begin
                lo_next = tab_q;
            end
            OP_TAB_HI: begin
                hi_next = tab_q;
            end
            OP_MUL_INT, OP_MUL_E, OP_MUL_PV, OP_MUL_AD, OP_MUL_VF: begin
                prod_next = product;
            end
            OP_LOG_DONE: begin
                neg_next = neg_full[NW] ? '0 : neg_full[NW-1:0];
            end
            OP_EXP_PREP: begin
                n_next     = e_val[NW-1:FRAC_BITS];
                gz_next    = (g_val == '0);
                ifrac_next = one_minus_g[FRAC_BITS-1:0];
                tsel_next  = 1'b1;
            end
            OP_EXP_DONE: begin
                if (gz_reg) begin
                    factor_next = FW'(ONE_Q >> n_reg);
                end else begin
                    factor_next = FW'(eh_pos >> ((NN + 1)'(n_reg) + (NN + 1)'(1)));
                end
            end
            OP_POS_FM: begin
                // position uses the old velocity; force product starts here
                s_tmp = sat32(SUM_W'($signed(pos_reg[cmd.ax])) + SUM_W'(prod_sh));
                pos_next[cmd.ax] = s_tmp[Q_W-1:0];
                if (s_tmp[Q_W]) begin
                    sat_next = 1'b1;
                end
                prod_next = product;
            end
            OP_ACC: begin
                s_tmp = sat32(SUM_W'($signed(accel[cmd.ax])) + SUM_W'(prod_sh));
                a_next = s_tmp[Q_W-1:0];
                if (s_tmp[Q_W]) begin
                    sat_next = 1'b1;
                end
            end
            OP_VSUM: begin
                s_tmp = sat32(SUM_W'($signed(vel_reg[cmd.ax])) + SUM_W'(prod_sh));
                v_next = s_tmp[Q_W-1:0];
                if (s_tmp[Q_W]) begin
                    sat_next = 1'b1;
                end
            end
            OP_VEL: begin
                vel_next[cmd.ax] = prod_sh[Q_W-1:0];
            end
            default: begin
                prod_next = prod_reg;
            end
        endcase
    end

    // particle state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            vel_reg <= '0;
            frc_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            frc_reg <= frc_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        vin_reg    <= vin_next;
        req_reg    <= req_next;
        dt_reg     <= dt_next;
        sat_reg    <= sat_next;
        skip_reg   <= skip_next;
        ifrac_reg  <= ifrac_next;
        tsel_reg   <= tsel_next;
        idx_reg    <= idx_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        p_reg      <= p_next;
        neg_reg    <= neg_next;
        n_reg      <= n_next;
        gz_reg     <= gz_next;
        factor_reg <= factor_next;
        a_reg      <= a_next;
        v_reg      <= v_next;
        prod_reg   <= prod_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_pos_reg  <= pos_reg;
            out_vel_reg  <= vel_reg;
            out_skip_reg <= skip_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign out_pos       = out_pos_reg;
    assign out_vel       = out_vel_reg;
    assign out_skipped   = out_skip_reg;
    assign out_saturated = out_sat_reg;

endmodule

// ----- rtl/core/particle_euler_integrator.sv -----
// ----------------------------------------------------------------------------
// particle_euler_integrator
// One particle in signed Q16.16: add or clear forces, load position or
// velocity, or integrate one damped Euler step over dt.
//
//   channel   direction   handshake              payload
//   s_        in          s_valid / s_ready      req_type, vec_x/y/z, delta_time
//   m_        out         m_valid / m_ready      pos_x/y/z, vel_x/y/z, skipped,
//                                                saturated
//   cfg_      in          cfg_wr_en              cfg_index, cfg_wr_data
//
// Force, clear, load and unknown requests pass only START and FINISH. Integrate
// runs the damping power (skipped when trivially 0 or 1), then the per-axis
// update; one shared 33x33 multiplier does every product, 15 in a full step.
// A finished result waits in an output register, and the next item is taken
// while it waits. Reset clears the state vectors and loads register defaults.
// ----------------------------------------------------------------------------
module particle_euler_integrator #(
    parameter int POW_TABLE_ENTRIES = pei_pkg::POW_ENTRIES_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pei_pkg::REQ_W-1:0]         s_req_type,
    input  logic signed [pei_pkg::Q_W-1:0]    s_vec_x,
    input  logic signed [pei_pkg::Q_W-1:0]    s_vec_y,
    input  logic signed [pei_pkg::Q_W-1:0]    s_vec_z,
    input  logic [pei_pkg::DT_W-1:0]          s_delta_time,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pei_pkg::Q_W-1:0]    m_pos_x,
    output logic signed [pei_pkg::Q_W-1:0]    m_pos_y,
    output logic signed [pei_pkg::Q_W-1:0]    m_pos_z,
    output logic signed [pei_pkg::Q_W-1:0]    m_vel_x,
    output logic signed [pei_pkg::Q_W-1:0]    m_vel_y,
    output logic signed [pei_pkg::Q_W-1:0]    m_vel_z,
    output logic                              m_skipped,
    output logic                              m_saturated,
    input  logic                              cfg_wr_en,
    input  logic [pei_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pei_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import pei_pkg::*;

    logic [DAMP_W-1:0] damping_reg;
    logic [MASS_W-1:0] inv_mass_reg;
    vec_t              accel_reg;

    dp_cmd_t    cmd;
    dp_status_t status;
    vec_t       out_pos;
    vec_t       out_vel;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damping_reg  <= DAMP_W'(ONE_Q);
            inv_mass_reg <= MASS_W'(ONE_Q);
            accel_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DAMPING:  damping_reg  <= cfg_wr_data[DAMP_W-1:0];
                CFG_INV_MASS: inv_mass_reg <= cfg_wr_data[MASS_W-1:0];
                CFG_ACCEL_X:  accel_reg[0] <= cfg_wr_data[Q_W-1:0];
                CFG_ACCEL_Y:  accel_reg[1] <= cfg_wr_data[Q_W-1:0];
                CFG_ACCEL_Z:  accel_reg[2] <= cfg_wr_data[Q_W-1:0];
                default: begin
                    damping_reg <= damping_reg;
                end
            endcase
        end
    end

    // sequencer
    pei_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and state
    pei_datapath #(
        .POW_TABLE_ENTRIES (POW_TABLE_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_req        (s_req_type),
        .in_vec_x      (s_vec_x),
        .in_vec_y      (s_vec_y),
        .in_vec_z      (s_vec_z),
        .in_dt         (s_delta_time),
        .damping       (damping_reg),
        .inv_mass      (inv_mass_reg),
        .accel         (accel_reg),
        .out_pos       (out_pos),
        .out_vel       (out_vel),
        .out_skipped   (m_skipped),
        .out_saturated (m_saturated)
    );

    assign m_pos_x = out_pos[0];
    assign m_pos_y = out_pos[1];
    assign m_pos_z = out_pos[2];
    assign m_vel_x = out_vel[0];
    assign m_vel_y = out_vel[1];
    assign m_vel_z = out_vel[2];

endmodule
